// File: design/rcab_pkg.sv
// Shared types, constants and helpers for the reorder buffer with cumulative ack.
// No dependencies; every other design file but rcab_if imports this package.
`default_nettype none

package rcab_pkg;

   // Default number of early packets the store can hold
   localparam int unsigned HOLD_DEPTH_DEF = 32;
   // Largest payload length; longer lengths are clipped to it
   localparam int unsigned MAX_PAYLOAD    = 2000;

   typedef enum logic [1:0] {
      MODE_ACK     = 2'd0,
      MODE_DATA    = 2'd1,
      MODE_FIN     = 2'd2,
      MODE_FIN_ACK = 2'd3
   } rcab_mode_type;

   typedef enum logic [1:0] {
      KIND_DELIVER = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_FIN_ACK = 2'd2
   } rcab_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DELIV,
      ST_SCAN,
      ST_CHECK,
      ST_DRAIN,
      ST_SHIFT,
      ST_ACK,
      ST_FIN
   } rcab_state_type;

   // One incoming packet header
   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] seq_start;
      logic [10:0] length;
      logic [7:0]  payload_tag;
   } rcab_item_type;

   // One stored early packet
   typedef struct packed {
      logic [31:0] seq;
      logic [10:0] length;
      logic [7:0]  tag;
   } rcab_entry_type;

   // One outgoing result
   typedef struct packed {
      rcab_kind_type kind;
      logic [31:0]   out_seq;
      logic [10:0]   out_length;
      logic [7:0]    out_tag;
      logic [31:0]   ack_index;
      logic          last;
   } rcab_result_type;

   // Sequencer status seen by the top level
   typedef struct packed {
      logic idle;
      logic finished;
   } rcab_status_type;

   // Clip a length to the largest payload
   function automatic logic [10:0] sat_length(input logic [10:0] len);
      logic [15:0] max_pay;
      max_pay = 16'(MAX_PAYLOAD);
      if ({5'd0, len} > max_pay) begin
         return max_pay[10:0];
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// File: design/rcab_if.sv
// Valid/ready channel interfaces for packet headers and results.
// Plain payload bits; no package dependency.
`default_nettype none

interface rcab_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] seq_start;
   logic [10:0] length;
   logic [7:0]  payload_tag;

   modport source (output valid, mode, seq_start, length, payload_tag, input ready);
   modport sink   (input valid, mode, seq_start, length, payload_tag, output ready);
endinterface

interface rcab_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] out_seq;
   logic [10:0] out_length;
   logic [7:0]  out_tag;
   logic [31:0] ack_index;
   logic        last;

   modport source (output valid, kind, out_seq, out_length, out_tag, ack_index, last,
                   input ready);
   modport sink   (input valid, kind, out_seq, out_length, out_tag, ack_index, last,
                   output ready);
endinterface

`default_nettype wire

// File: design/rcab_store.sv
// Single-write, single-read store of early packets with registered read data.
// Depends on rcab_pkg for the entry type.
`default_nettype none

module rcab_store #(
   parameter int unsigned HOLD_DEPTH = rcab_pkg::HOLD_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(HOLD_DEPTH)-1:0] wr_addr,
   input  wire rcab_pkg::rcab_entry_type      wr_data,
   input  wire logic [$clog2(HOLD_DEPTH)-1:0] rd_addr,
   output rcab_pkg::rcab_entry_type           rd_data
);
   import rcab_pkg::*;

   rcab_entry_type entries_ff [HOLD_DEPTH];
   rcab_entry_type rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entries_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/rcab_seq.sv
// Sequencer with one shared 32-bit compare unit and one expected-index adder.
// Depends on rcab_pkg; drives the rcab_store ports.
`default_nettype none

module rcab_seq #(
   parameter int unsigned HOLD_DEPTH = rcab_pkg::HOLD_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire rcab_pkg::rcab_item_type       in_item,
   input  wire logic                          emit_ok,
   output logic                               emit,
   output rcab_pkg::rcab_result_type          result,
   output rcab_pkg::rcab_status_type          status,
   output logic                               mem_we,
   output logic [$clog2(HOLD_DEPTH)-1:0]      mem_waddr,
   output rcab_pkg::rcab_entry_type           mem_wdata,
   output logic [$clog2(HOLD_DEPTH)-1:0]      mem_raddr,
   input  wire rcab_pkg::rcab_entry_type      mem_rdata
);
   import rcab_pkg::*;

   localparam int unsigned AW = $clog2(HOLD_DEPTH);
   localparam int unsigned CW = $clog2(HOLD_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(HOLD_DEPTH);

   rcab_state_type state_ff, state_in;
   logic [31:0]    exp_ff, exp_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           fin_ff, fin_in;
   rcab_entry_type cur_ff, cur_in;
   logic           cur_data_ff, cur_data_in;
   rcab_entry_type best_ff, best_in;
   logic [AW-1:0]  best_pos_ff, best_pos_in;
   logic           have_best_ff, have_best_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  dst_ff, dst_in;
   logic           pend_ff, pend_in;

   logic          accept;
   logic [31:0]   cmp_a, cmp_b;
   logic          cmp_lt, cmp_eq;
   logic [10:0]   add_len;
   logic [31:0]   sum;
   logic          idx_more;

   assign accept   = in_valid && in_ready;
   assign idx_more = idx_ff < count_ff;

   // Shared compare unit and expected-index adder
   assign cmp_lt = cmp_a < cmp_b;
   assign cmp_eq = cmp_a == cmp_b;
   assign sum    = exp_ff + {21'd0, add_len};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !fin_ff) begin
               if (in_item.mode == MODE_FIN) begin
                  state_in = ST_FIN;
               end else if (in_item.mode == MODE_DATA) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            state_in = (cmp_eq && cur_data_ff) ? ST_DELIV : ST_ACK;
         end
         ST_DELIV: begin
            if (emit_ok) begin
               state_in = (count_ff == '0) ? ST_ACK : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!pend_ff && !idx_more) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = cmp_eq ? ST_DRAIN : ST_ACK;
         end
         ST_DRAIN: begin
            if (emit_ok) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (!pend_ff && !idx_more) begin
               state_in = (count_ff == CW'(1)) ? ST_ACK : ST_SCAN;
            end
         end
         ST_ACK, ST_FIN: begin
            if (emit_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake, result, compare operands and store controls
   always_comb begin
      in_ready  = 1'b0;
      emit      = 1'b0;
      result    = '{kind: KIND_ACK, out_seq: '0, out_length: '0, out_tag: '0,
                    ack_index: exp_ff, last: 1'b0};
      cmp_a     = exp_ff;
      cmp_b     = cur_ff.seq;
      add_len   = cur_ff.length;
      mem_we    = 1'b0;
      mem_waddr = count_ff[AW-1:0];
      mem_wdata = cur_ff;
      mem_raddr = idx_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
         end
         ST_EVAL: begin
            // Early packet goes into the store while there is room
            if (cmp_lt && cur_data_ff && (count_ff < DEPTH_C)) begin
               mem_we = 1'b1;
            end
         end
         ST_DELIV: begin
            emit   = emit_ok;
            result = '{kind: KIND_DELIVER, out_seq: cur_ff.seq, out_length: cur_ff.length,
                       out_tag: cur_ff.tag, ack_index: sum, last: 1'b0};
         end
         ST_SCAN: begin
            cmp_a = mem_rdata.seq;
            cmp_b = best_ff.seq;
         end
         ST_CHECK: begin
            cmp_a = best_ff.seq;
            cmp_b = exp_ff;
         end
         ST_DRAIN: begin
            add_len = best_ff.length;
            emit    = emit_ok;
            result  = '{kind: KIND_DELIVER, out_seq: best_ff.seq,
                        out_length: best_ff.length, out_tag: best_ff.tag,
                        ack_index: sum, last: 1'b0};
         end
         ST_SHIFT: begin
            // Move each later entry one place down
            mem_we    = pend_ff;
            mem_waddr = dst_ff;
            mem_wdata = mem_rdata;
         end
         ST_ACK: begin
            emit        = emit_ok;
            result.last = 1'b1;
         end
         ST_FIN: begin
            emit        = emit_ok;
            result.kind = KIND_FIN_ACK;
            result.last = 1'b1;
         end
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      exp_in       = exp_ff;
      count_in     = count_ff;
      fin_in       = fin_ff;
      cur_in       = cur_ff;
      cur_data_in  = cur_data_ff;
      best_in      = best_ff;
      best_pos_in  = best_pos_ff;
      have_best_in = have_best_ff;
      idx_in       = idx_ff;
      dst_in       = dst_ff;
      pend_in      = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in      = '{seq: in_item.seq_start, length: sat_length(in_item.length),
                               tag: in_item.payload_tag};
               cur_data_in = in_item.mode == MODE_DATA;
            end
         end
         ST_EVAL: begin
            if (mem_we) begin
               count_in = count_ff + CW'(1);
            end
         end
         ST_DELIV: begin
            if (emit_ok) begin
               exp_in = sum;
            end
         end
         ST_SCAN: begin
            // Keep the earliest-stored smallest sequence
            if (pend_ff) begin
               have_best_in = 1'b1;
               if (!have_best_ff || cmp_lt) begin
                  best_in     = mem_rdata;
                  best_pos_in = dst_ff;
               end
            end
            pend_in = idx_more;
            if (idx_more) begin
               dst_in = idx_ff[AW-1:0];
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_DRAIN: begin
            if (emit_ok) begin
               exp_in  = sum;
               idx_in  = CW'(best_pos_ff) + CW'(1);
               pend_in = 1'b0;
            end
         end
         ST_SHIFT: begin
            pend_in = idx_more;
            if (idx_more) begin
               dst_in = AW'(idx_ff - CW'(1));
               idx_in = idx_ff + CW'(1);
            end else if (!pend_ff) begin
               count_in = count_ff - CW'(1);
            end
         end
         ST_FIN: begin
            if (emit_ok) begin
               fin_in = 1'b1;
            end
         end
         default: begin
            fin_in = fin_ff;
         end
      endcase
      // Fresh search whenever a scan begins
      if (state_in == ST_SCAN && state_ff != ST_SCAN) begin
         idx_in       = '0;
         pend_in      = 1'b0;
         have_best_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         exp_ff   <= '0;
         count_ff <= '0;
         fin_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         exp_ff   <= exp_in;
         count_ff <= count_in;
         fin_ff   <= fin_in;
         pend_ff  <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      cur_data_ff  <= cur_data_in;
      best_ff      <= best_in;
      best_pos_ff  <= best_pos_in;
      have_best_ff <= have_best_in;
      idx_ff       <= idx_in;
      dst_ff       <= dst_in;
   end

   assign status = '{idle: state_ff == ST_IDLE, finished: fin_ff};

endmodule

`default_nettype wire

// File: design/reorder_buffer_cumulative_ack_top.sv
// Top level of the reorder buffer with cumulative ack: sequencer, store, result register.
// Depends on rcab_pkg, rcab_if, rcab_store and rcab_seq.
`default_nettype none

// Takes one packet header per transaction on req_ch and answers on rsp_ch. An ignored
// header (ack, fin_ack, or anything after fin) is accepted and dropped; a fin steps
// through accept and fin_ack. A stale packet, or an early packet that goes into the
// store, steps through accept, compare, ack. An in-order packet steps through accept,
// compare, deliver and ack when the store is empty. With n packets held, each search for
// the smallest held sequence reads them one by one through the single registered read
// port of the store, then makes its final compare. A match is delivered, then the gap is
// closed by moving each later entry one place down. No further search runs once the
// store is empty. Otherwise the search that finds no match ends in the ack. A result
// register sits between the sequencer and rsp_ch, so the sequencer waits only on a full
// register, and only in the cycles that hand over a result.
module reorder_buffer_cumulative_ack_top #(
   parameter int unsigned HOLD_DEPTH = rcab_pkg::HOLD_DEPTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   rcab_req_if.sink   req_ch,
   rcab_rsp_if.source rsp_ch
);
   import rcab_pkg::*;

   localparam int unsigned AW = $clog2(HOLD_DEPTH);

   rcab_item_type   item;
   rcab_result_type result;
   rcab_status_type status;
   logic            emit;
   logic            emit_ok;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [AW-1:0]   mem_raddr;
   rcab_entry_type  mem_wdata;
   rcab_entry_type  mem_rdata;

   logic            rsp_valid_ff, rsp_valid_in;
   rcab_result_type rsp_data_ff, rsp_data_in;

   assign item = '{mode: req_ch.mode, seq_start: req_ch.seq_start,
                   length: req_ch.length, payload_tag: req_ch.payload_tag};

   rcab_seq #(
      .HOLD_DEPTH(HOLD_DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_item   (item),
      .emit_ok   (emit_ok),
      .emit      (emit),
      .result    (result),
      .status    (status),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   rcab_store #(
      .HOLD_DEPTH(HOLD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Result register: loads when empty or being drained
   assign emit_ok = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = rsp_data_ff.kind;
   assign rsp_ch.out_seq    = rsp_data_ff.out_seq;
   assign rsp_ch.out_length = rsp_data_ff.out_length;
   assign rsp_ch.out_tag    = rsp_data_ff.out_tag;
   assign rsp_ch.ack_index  = rsp_data_ff.ack_index;
   assign rsp_ch.last       = rsp_data_ff.last;

`ifndef ASSERT_OFF
   // A result is never loaded over one that has not been taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> emit_ok)
      else $error("result register overwritten");

   // Once fin is answered the block stays finished
   a_fin_sticky: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(status.finished)) |-> status.finished)
      else $error("finished flag cleared");

   // Headers taken after fin leave the sequencer idle
   a_fin_ignore: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && status.finished) |=> status.idle)
      else $error("header acted on after fin");

   // A fin_ack result marks the block finished
   a_fin_ack: assert property (@(posedge clock) disable iff (reset)
      (emit && result.kind == KIND_FIN_ACK) |=> status.finished)
      else $error("fin_ack without finish");
`endif

endmodule

`default_nettype wire
